>>> rtl/core/nearest_point_search_macros.svh
`ifndef NEAREST_POINT_SEARCH_MACROS_SVH
`define NEAREST_POINT_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_point_search: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_point_search: next-cycle check failed");

`endif

>>> rtl/core/nps_pkg.sv
package nps_pkg;

    localparam int CMD_BITS   = 2;
    localparam int INDEX_BITS = 8;

    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic vld;
        logic last;
    } nps_tag_t;

endpackage

>>> rtl/core/nps_cmd_if.sv
interface nps_cmd_if
    import nps_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   command;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;

    modport source (output valid, command, coord_x, coord_y, input ready);
    modport sink   (input valid, command, coord_x, coord_y, output ready);
endinterface

>>> rtl/core/nps_res_if.sv
interface nps_res_if
    import nps_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] nearest_index;
    logic                  table_empty;

    modport source (output valid, nearest_index, table_empty, input ready);
    modport sink   (input valid, nearest_index, table_empty, output ready);
endinterface

>>> rtl/core/nearest_point_search.sv
// Load, clear and unused commands leave the block in idle; it is ready again next cycle.
// A query over N stored points runs through scan, drain and finish states to the result: one memory
// read per cycle feeds a three-stage distance unit and a running minimum compare.
// A query on an empty table skips the scan and goes straight to finish, where its result is registered.
// rst_n is asynchronous, active low: empties the table and drops any pending result;
// point memory contents are not reset.
module nearest_point_search
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 12
)(
    input  logic      clk,
    input  logic      rst_n,
    nps_cmd_if.sink   cmd,
    nps_res_if.source res
);

`include "nearest_point_search_macros.svh"

    localparam int IDXW    = $clog2(MAX_POINTS);
    localparam int CNTW    = $clog2(MAX_POINTS + 1);
    localparam int DISTW   = 2 * COORD_BITS + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];

    logic [1:0]            state_reg, state_next;
    logic [CNTW-1:0]       count_reg, count_next;
    logic [IDXW-1:0]       scan_idx_reg, scan_idx_next;
    logic [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                  empty_reg, empty_next;

    nps_tag_t              rd_tag_reg, rd_tag_next;
    logic [IDXW-1:0]       rd_idx_reg;
    logic [COORD_BITS-1:0] rd_x_reg, rd_y_reg;

    nps_tag_t              d_tag;
    logic [IDXW-1:0]       d_idx;
    logic [DISTW-1:0]      d_dist;

    logic [IDXW-1:0]       best_idx_reg;
    logic [DISTW-1:0]      best_d_reg;
    logic                  take_best;

    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0] out_idx_reg;
    logic                  out_empty_reg;

    logic                  cmd_acc;
    logic                  mem_we;
    logic                  scan_last;
    logic                  out_load;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign mem_we     = cmd_acc && (cmd.command == CMD_LOAD) && (count_reg < CNTW'(MAX_POINTS));
    assign scan_last  = ((CNTW'(scan_idx_reg) + CNTW'(1)) == count_reg);
    assign out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);
    assign take_best  = d_tag.vld && ((d_idx == '0) || (d_dist < best_d_reg));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        empty_next    = empty_reg;
        rd_tag_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (cmd.command)
                        CMD_LOAD:
                        begin
                            if (mem_we)
                                count_next = count_reg + CNTW'(1);
                        end
                        CMD_CLEAR:
                            count_next = '0;
                        CMD_QUERY:
                        begin
                            scan_idx_next = '0;
                            if (count_reg == '0)
                            begin
                                empty_next = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                empty_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_tag_next.vld  = 1'b1;
                rd_tag_next.last = scan_last;
                if (scan_last)
                    state_next = ST_DRAIN;
                else
                    scan_idx_next = scan_idx_reg + IDXW'(1);
            end
            ST_DRAIN:
            begin
                if (d_tag.vld && d_tag.last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            empty_reg     <= 1'b0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            empty_reg     <= empty_next;
            rd_tag_reg    <= rd_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[count_reg[IDXW-1:0]] <= cmd.coord_x;
            mem_y[count_reg[IDXW-1:0]] <= cmd.coord_y;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_x_reg <= mem_x[scan_idx_reg];
            rd_y_reg <= mem_y[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        if (cmd_acc && (cmd.command == CMD_QUERY))
        begin
            qx_reg <= cmd.coord_x;
            qy_reg <= cmd.coord_y;
        end
        if (cmd_acc && (cmd.command == CMD_QUERY))
            best_idx_reg <= '0;
        else if (take_best)
        begin
            best_idx_reg <= d_idx;
            best_d_reg   <= d_dist;
        end
        if (out_load)
        begin
            out_idx_reg   <= empty_reg ? '0 : INDEX_BITS'(best_idx_reg);
            out_empty_reg <= empty_reg;
        end
    end

    nps_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IDXW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (rd_tag_reg),
        .in_idx   (rd_idx_reg),
        .px       (rd_x_reg),
        .py       (rd_y_reg),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .out_tag  (d_tag),
        .out_idx  (d_idx),
        .out_dist (d_dist)
    );

    assign res.valid         = out_valid_reg;
    assign res.nearest_index = out_idx_reg;
    assign res.table_empty   = out_empty_reg;

    `NPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNTW'(MAX_POINTS))
    `NPS_ASSERT_NEXT(a_query_scan, cmd_acc && (cmd.command == CMD_QUERY) && (count_reg != '0), state_reg == ST_SCAN)
    `NPS_ASSERT_NOW(a_empty_index, res.valid && res.table_empty, res.nearest_index == '0)
    `NPS_ASSERT_NOW(a_dist_in_scan, d_tag.vld, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))

endmodule

>>> rtl/core/nps_dist_unit.sv
module nps_dist_unit
    import nps_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int IDX_BITS   = 8
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  nps_tag_t                in_tag,
    input  logic [IDX_BITS-1:0]     in_idx,
    input  logic [COORD_BITS-1:0]   px,
    input  logic [COORD_BITS-1:0]   py,
    input  logic [COORD_BITS-1:0]   qx,
    input  logic [COORD_BITS-1:0]   qy,
    output nps_tag_t                out_tag,
    output logic [IDX_BITS-1:0]     out_idx,
    output logic [2*COORD_BITS:0]   out_dist
);

    localparam int SQ_BITS = 2 * COORD_BITS;

    nps_tag_t                tag1_reg, tag2_reg, tag3_reg;
    logic [IDX_BITS-1:0]     idx1_reg, idx2_reg, idx3_reg;
    logic [COORD_BITS-1:0]   dx_reg, dy_reg;
    logic [SQ_BITS-1:0]      sqx_reg, sqy_reg;
    logic [SQ_BITS:0]        dist_reg;
    logic [COORD_BITS-1:0]   dx_next, dy_next;

    assign dx_next = (px >= qx) ? (px - qx) : (qx - px);
    assign dy_next = (py >= qy) ? (py - qy) : (qy - py);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= in_idx;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        idx2_reg <= idx1_reg;
        sqx_reg  <= SQ_BITS'(dx_reg) * SQ_BITS'(dx_reg);
        sqy_reg  <= SQ_BITS'(dy_reg) * SQ_BITS'(dy_reg);
        idx3_reg <= idx2_reg;
        dist_reg <= (SQ_BITS+1)'(sqx_reg) + (SQ_BITS+1)'(sqy_reg);
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_dist = dist_reg;

endmodule
